FILE: sv/cal_pkg.sv
// Shared package for the circular array list: request opcodes, cell modes
// and fixed field widths. No dependencies.
package cal_pkg;

    // Field widths of the request and result transactions
    localparam int unsigned OP_W    = 4;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned FOUND_W = 7;
    localparam int unsigned OCC_W   = 7;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT  = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK   = 4'd1;
    localparam logic [OP_W-1:0] OP_INSERT_AT   = 4'd2;
    localparam logic [OP_W-1:0] OP_DELETE_AT   = 4'd3;
    localparam logic [OP_W-1:0] OP_DELETE_HEAD = 4'd4;
    localparam logic [OP_W-1:0] OP_DELETE_TAIL = 4'd5;
    localparam logic [OP_W-1:0] OP_READ        = 4'd6;
    localparam logic [OP_W-1:0] OP_FIND        = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR       = 4'd8;

    // What every cell of the chain does in a cycle
    typedef logic [2:0] t_cell_mode;

    localparam t_cell_mode CELL_HOLD       = 3'd0;
    localparam t_cell_mode CELL_WRITE      = 3'd1;  // cell at target loads data
    localparam t_cell_mode CELL_SHIFT_UP   = 3'd2;  // open a gap at target, load data there
    localparam t_cell_mode CELL_SHIFT_DOWN = 3'd3;  // close the gap at target
    localparam t_cell_mode CELL_ROTATE     = 3'd4;  // rotate live cells toward 0

endpackage

FILE: sv/cal_cell.sv
// One storage cell of the list chain: holds the word at logical index IDX.
// Depends on cal_pkg.
module cal_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned XW  = 7
) (
    input  logic                      i_clk,
    input  cal_pkg::t_cell_mode       i_mode,
    input  logic [XW-1:0]             i_target,
    input  logic [XW-1:0]             i_count,
    input  logic [cal_pkg::WORD_W-1:0] i_data,
    input  logic [cal_pkg::WORD_W-1:0] i_prev,
    input  logic [cal_pkg::WORD_W-1:0] i_next,
    input  logic [cal_pkg::WORD_W-1:0] i_first,
    output logic [cal_pkg::WORD_W-1:0] o_word
);
    import cal_pkg::*;

    localparam logic [XW-1:0] MY_IDX = XW'(IDX);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic [XW-1:0]     w_last;

    assign w_last = i_count - XW'(1);

    always_comb begin
        n_word = r_word;
        case (i_mode)
            CELL_WRITE: begin
                if (MY_IDX == i_target) n_word = i_data;
            end
            CELL_SHIFT_UP: begin
                if (MY_IDX > i_target) n_word = i_prev;
                else if (MY_IDX == i_target) n_word = i_data;
            end
            CELL_SHIFT_DOWN: begin
                if (MY_IDX >= i_target) n_word = i_next;
            end
            CELL_ROTATE: begin
                if (MY_IDX == w_last) n_word = i_first;
                else if (MY_IDX < w_last) n_word = i_next;
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

FILE: sv/circular_array_list.sv
// Circular array list, top level, built on cal_pkg and a chain of cal_cell.
// Push, insert, clear and failed requests give their result in the cycle after
// start and leave busy low; read and find rotate the chain once (ST_SCAN), and
// delete scans and then closes the gap (ST_CLOSE) before its result is registered.
// Busy is high from the scan until the result strobe; start is taken only while idle.
// Sync active-low reset empties the list, cells keep contents; strobe can't stall.
module circular_array_list #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cal_pkg::OP_W-1:0]     i_operation,
    input  logic [cal_pkg::POS_W-1:0]    i_position,
    input  logic signed [cal_pkg::WORD_W-1:0] i_data_word,
    output logic                         o_strobe,
    output logic                         o_ok,
    output logic signed [cal_pkg::WORD_W-1:0] o_read_word,
    output logic signed [cal_pkg::FOUND_W-1:0] o_found_position,
    output logic [cal_pkg::OCC_W-1:0]    o_occupancy
);
    import cal_pkg::*;

    // Count width, and a compare width wide enough for the count and for
    // the position and result fields.
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = (CW > OCC_W) ? CW : OCC_W;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;  // rotate the chain once, tapping cell 0
    localparam logic [1:0] ST_CLOSE = 2'd2;  // delete: close the gap

    localparam logic [WORD_W-1:0]  WORD_FAIL  = '1;
    localparam logic [FOUND_W-1:0] FOUND_NONE = '1;

    logic [1:0]          r_state, n_state;
    logic [XW-1:0]       r_count, n_count;   // items held
    logic [XW-1:0]       r_pos,   n_pos;     // logical index of the transaction
    logic [XW-1:0]       r_step,  n_step;    // logical index now in cell 0
    logic [OP_W-1:0]     r_op,    n_op;
    logic [WORD_W-1:0]   r_data,  n_data;
    logic [WORD_W-1:0]   r_word,  n_word;    // word captured during the scan
    logic                r_hit,   n_hit;
    logic [FOUND_W-1:0]  r_found, n_found;

    // Result register
    logic                r_strobe, n_strobe;
    logic                r_ok,     n_ok;
    logic [WORD_W-1:0]   r_res_word, n_res_word;
    logic [FOUND_W-1:0]  r_res_found, n_res_found;
    logic [OCC_W-1:0]    r_res_occ,   n_res_occ;

    // Chain control
    t_cell_mode          w_mode;
    logic [XW-1:0]       w_target;
    logic [WORD_W-1:0]   w_words [CAPACITY];

    logic [XW-1:0]       w_pos_in;
    logic                w_not_full;
    logic                w_pos_ok;
    logic                w_match;
    logic                w_hit_now;
    logic [FOUND_W-1:0]  w_found_now;
    logic [WORD_W-1:0]   w_word_now;

    assign w_pos_in   = XW'(i_position);
    assign w_not_full = (r_count < CAP_X);
    assign w_pos_ok   = (w_pos_in < r_count);

    // Scan tap: cell 0 holds logical index r_step during ST_SCAN
    assign w_match     = (w_words[0] == r_data);
    assign w_hit_now   = r_hit | w_match;
    assign w_found_now = w_match ? r_step[FOUND_W-1:0] : r_found;
    assign w_word_now  = (r_step == r_pos) ? w_words[0] : r_word;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_step      = r_step;
        n_op        = r_op;
        n_data      = r_data;
        n_word      = r_word;
        n_hit       = r_hit;
        n_found     = r_found;
        n_strobe    = 1'b0;
        n_ok        = r_ok;
        n_res_word  = r_res_word;
        n_res_found = r_res_found;
        n_res_occ   = r_res_occ;
        w_mode      = CELL_HOLD;
        w_target    = w_pos_in;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    // default: failed transaction, state unchanged
                    n_strobe    = 1'b1;
                    n_ok        = 1'b0;
                    n_res_word  = WORD_FAIL;
                    n_res_found = FOUND_NONE;
                    n_res_occ   = r_count[OCC_W-1:0];
                    n_op        = i_operation;
                    n_data      = i_data_word;
                    n_step      = '0;
                    n_hit       = 1'b0;
                    n_found     = FOUND_NONE;
                    n_word      = WORD_FAIL;
                    case (i_operation)
                        OP_PUSH_FRONT: begin
                            if (w_not_full) begin
                                w_mode     = CELL_SHIFT_UP;
                                w_target   = '0;
                                n_count    = r_count + XW'(1);
                                n_ok       = 1'b1;
                                n_res_word = '0;
                                n_res_occ  = n_count[OCC_W-1:0];
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (w_not_full) begin
                                w_mode     = CELL_WRITE;
                                w_target   = r_count;
                                n_count    = r_count + XW'(1);
                                n_ok       = 1'b1;
                                n_res_word = '0;
                                n_res_occ  = n_count[OCC_W-1:0];
                            end
                        end
                        OP_INSERT_AT: begin
                            if (w_pos_ok && w_not_full) begin
                                w_mode     = CELL_SHIFT_UP;
                                w_target   = w_pos_in;
                                n_count    = r_count + XW'(1);
                                n_ok       = 1'b1;
                                n_res_word = '0;
                                n_res_occ  = n_count[OCC_W-1:0];
                            end
                        end
                        OP_DELETE_AT, OP_READ: begin
                            if (w_pos_ok) begin
                                n_strobe = 1'b0;
                                n_pos    = w_pos_in;
                                n_state  = ST_SCAN;
                            end
                        end
                        OP_DELETE_HEAD: begin
                            if (r_count != '0) begin
                                n_strobe = 1'b0;
                                n_pos    = '0;
                                n_state  = ST_SCAN;
                            end
                        end
                        OP_DELETE_TAIL: begin
                            if (r_count != '0) begin
                                n_strobe = 1'b0;
                                n_pos    = r_count - XW'(1);
                                n_state  = ST_SCAN;
                            end
                        end
                        OP_FIND: begin
                            if (r_count != '0) begin
                                n_strobe = 1'b0;
                                n_pos    = CAP_X;   // no positional capture
                                n_state  = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_count    = '0;
                            n_ok       = 1'b1;
                            n_res_word = '0;
                            n_res_occ  = '0;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // One rotation step per cycle; after count steps the chain is
                // back in its original order.
                w_mode  = CELL_ROTATE;
                n_word  = w_word_now;
                n_hit   = w_hit_now;
                n_found = w_found_now;
                n_step  = r_step + XW'(1);
                if (r_step == r_count - XW'(1)) begin
                    if (r_op == OP_READ) begin
                        n_state     = ST_IDLE;
                        n_strobe    = 1'b1;
                        n_ok        = 1'b1;
                        n_res_word  = w_word_now;
                        n_res_found = FOUND_NONE;
                        n_res_occ   = r_count[OCC_W-1:0];
                    end else if (r_op == OP_FIND) begin
                        n_state     = ST_IDLE;
                        n_strobe    = 1'b1;
                        n_ok        = w_hit_now;
                        n_res_word  = w_hit_now ? r_data : WORD_FAIL;
                        n_res_found = w_found_now;
                        n_res_occ   = r_count[OCC_W-1:0];
                    end else begin
                        n_state = ST_CLOSE;
                    end
                end
            end

            ST_CLOSE: begin
                w_mode      = CELL_SHIFT_DOWN;
                w_target    = r_pos;
                n_count     = r_count - XW'(1);
                n_state     = ST_IDLE;
                n_strobe    = 1'b1;
                n_ok        = 1'b1;
                n_res_word  = r_word;
                n_res_found = FOUND_NONE;
                n_res_occ   = n_count[OCC_W-1:0];
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // Transaction context and result payload
    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_step      <= n_step;
        r_op        <= n_op;
        r_data      <= n_data;
        r_word      <= n_word;
        r_hit       <= n_hit;
        r_found     <= n_found;
        r_ok        <= n_ok;
        r_res_word  <= n_res_word;
        r_res_found <= n_res_found;
        r_res_occ   <= n_res_occ;
    end

    // The chain of cells: cell g holds logical index g.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_W-1:0] w_prev;
        logic [WORD_W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_words[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_next
            assign w_next = w_words[g+1];
        end

        cal_cell #(
            .IDX (g),
            .XW  (XW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_mode   (w_mode),
            .i_target (w_target),
            .i_count  (r_count),
            .i_data   (i_data_word),
            .i_prev   (w_prev),
            .i_next   (w_next),
            .i_first  (w_words[0]),
            .o_word   (w_words[g])
        );
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_strobe         = r_strobe;
    assign o_ok             = r_ok;
    assign o_read_word      = r_res_word;
    assign o_found_position = r_res_found;
    assign o_occupancy      = r_res_occ;

endmodule
